// ===== src/rc_pulse_channel_decoder_unmix_core_assert.svh =====
// Assertion macros used by the decoder's checker file.
`ifndef RC_PULSE_CHANNEL_DECODER_UNMIX_CORE_ASSERT_SVH
`define RC_PULSE_CHANNEL_DECODER_UNMIX_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RCPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RCPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rcpd_pkg.sv =====
// Shared types and constants of the pulse channel decoder.
package rcpd_pkg;

	localparam int NUM_CH     = 6;
	localparam int CH_W       = 16;
	localparam int IDX_W      = 4;
	localparam int QDEPTH     = 2;

	localparam logic [IDX_W-1:0] IDX_LIMIT = 4'd10;
	localparam logic [IDX_W-1:0] LAST_CH   = 4'd5;

	// register indexes on the configuration port
	localparam logic [1:0] REG_GAP    = 2'd0;
	localparam logic [1:0] REG_MIN    = 2'd1;
	localparam logic [1:0] REG_OFFSET = 2'd2;

	localparam logic [31:0] GAP_RESET    = 32'd40000;
	localparam logic [31:0] MIN_RESET    = 32'd8000;
	localparam logic [31:0] OFFSET_RESET = 32'd15238;

	// unmixing constants
	localparam logic [CH_W-1:0] THROTTLE_CAP = 16'd18368;
	localparam logic [7:0]      THROTTLE_OFS = 8'd31;
	localparam logic [7:0]      RUDDER_OFS   = 8'd10;
	localparam logic [7:0]      FRONT_OFS    = 8'h3a;
	localparam logic [CH_W-1:0] RIGHT_BASE   = 16'h0800;
	localparam logic [CH_W-1:0] GYRO_LIMIT   = 16'h2300;
	localparam logic [CH_W-1:0] KNOB_BASE    = 16'h0300;
	localparam logic [CH_W-1:0] KNOB_TOP     = 16'h4300;

	// one complete frame of channel widths
	typedef struct packed {
		logic [NUM_CH-1:0][CH_W-1:0] ch;
	} frame_t;

endpackage

// ===== src/rcpd_front.sv =====
// Front end: edge spacing, frame tracking and channel width capture.
module rcpd_front import rcpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] edge_time,
	input  logic [31:0] gap_ticks,
	input  logic [31:0] min_ticks,
	input  logic [31:0] offset_ticks,
	output logic        push,
	output frame_t      push_frame
);

	logic [31:0]                 last_q;
	logic [IDX_W-1:0]            idx_q;
	logic [NUM_CH-1:0][CH_W-1:0] width_q;
	logic [31:0]                 delta;
	logic                        is_gap;
	logic                        is_glitch;
	logic                        accept;
	logic                        store;
	logic [CH_W-1:0]             new_width;

	// classify the spacing to the last kept edge
	always_comb begin
		delta     = edge_time - last_q;
		is_gap    = delta > gap_ticks;
		is_glitch = !is_gap && (delta < min_ticks);
		accept    = in_valid && !in_stall;
		store     = accept && !is_gap && !is_glitch;
		new_width = delta[CH_W-1:0] - offset_ticks[CH_W-1:0];
	end

	// hand a finished frame to the queue, last channel taken fresh
	always_comb begin
		push_frame.ch              = width_q;
		push_frame.ch[NUM_CH-1]    = new_width;
		push                       = store && (idx_q == LAST_CH);
	end

	// advance frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			idx_q   <= '0;
			width_q <= '0;
		end else if (accept && is_gap) begin
			last_q <= edge_time;
			idx_q  <= '0;
		end else if (store) begin
			last_q <= edge_time;
			for (int i = 0; i < NUM_CH; i++) begin
				if (idx_q == IDX_W'(i)) begin
					width_q[i] <= new_width;
				end
			end
			if (idx_q < IDX_LIMIT) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== src/rcpd_queue.sv =====
// Two-entry frame queue between front end and unmixing stage.
module rcpd_queue import rcpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_frame,
	input  logic   pop,
	output logic   full,
	output logic   head_valid,
	output frame_t head_frame
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	frame_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full       = (cnt_q == CNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_frame = mem_q[rd_q];

	// store entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_frame;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/rcpd_back.sv =====
// Back end: unmix a frame into helicopter controls and hold the result.
module rcpd_back import rcpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  frame_t     head_frame,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] throttle,
	output logic [7:0] rudder,
	output logic [7:0] cyclic_front,
	output logic [7:0] cyclic_right,
	output logic       gyro_switch,
	output logic [7:0] right_knob,
	output logic [7:0] left_knob
);

	logic [CH_W-1:0] c0, c1, c2, c3, c4, c5;
	logic [CH_W-1:0] up, t_front, t_right, t_left, knob;
	logic [7:0]      thr_d, rud_d, front_d, right_d, rknob_d, left_d;
	logic            gyro_d;
	logic            out_valid_q;
	logic [7:0]      thr_q, rud_q, front_q, right_q, rknob_q, left_q;
	logic            gyro_q;

	// unmix in 16-bit modular arithmetic
	always_comb begin
		c0      = head_frame.ch[0];
		c1      = head_frame.ch[1];
		c2      = head_frame.ch[2];
		c3      = head_frame.ch[3];
		c4      = head_frame.ch[4];
		c5      = head_frame.ch[5];
		up      = (c2 >= THROTTLE_CAP) ? (THROTTLE_CAP - 1'b1) : c2;
		thr_d   = up[13:6] - THROTTLE_OFS;
		rud_d   = c3[13:6] - RUDDER_OFS;
		t_front = c0 - {c1[CH_W-2:0], 1'b0} - c5;
		front_d = t_front[15:8] - FRONT_OFS;
		t_right = RIGHT_BASE - c5 - c0;
		right_d = t_right[14:7];
		gyro_d  = c4 < GYRO_LIMIT;
		knob    = c4 - KNOB_BASE;
		rknob_d = (c4 >= KNOB_TOP) ? 8'hff : knob[12:5];
		t_left  = c0 + c1 - c5 - {1'b0, c2[CH_W-1:1]};
		left_d  = t_left[15:8];
	end

	// load the output register whenever it is empty or being taken
	assign pop = head_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			thr_q   <= thr_d;
			rud_q   <= rud_d;
			front_q <= front_d;
			right_q <= right_d;
			gyro_q  <= gyro_d;
			rknob_q <= rknob_d;
			left_q  <= left_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign throttle     = thr_q;
	assign rudder       = rud_q;
	assign cyclic_front = front_q;
	assign cyclic_right = right_q;
	assign gyro_switch  = gyro_q;
	assign right_knob   = rknob_q;
	assign left_knob    = left_q;

endmodule

// ===== src/rc_pulse_channel_decoder_unmix_core.sv =====
// The edge that completes channel 5 enters the frame queue at its accepting clock edge, and
// the result is registered from the queue head once the output register is empty or taken.
// Throughput: one edge per cycle while in_stall is low; the front end keeps spacing,
// index and widths in registers, and in_stall rises only when the two-entry
// frame queue is full behind a stalled output register.
// Reset: clears last edge time, channel index, widths, queue and output valid;
// configuration registers return to gap 40000, minimum 8000, offset 15238.
module rc_pulse_channel_decoder_unmix_core import rcpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] edge_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  throttle,
	output logic [7:0]  rudder,
	output logic [7:0]  cyclic_front,
	output logic [7:0]  cyclic_right,
	output logic        gyro_switch,
	output logic [7:0]  right_knob,
	output logic [7:0]  left_knob,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] gap_q, min_q, offset_q;
	logic        cfg_wr;
	logic [1:0]  reg_sel;
	logic        push, pop, q_full, head_valid;
	frame_t      push_frame, head_frame;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q    <= GAP_RESET;
			min_q    <= MIN_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_GAP:    gap_q    <= pwdata;
				REG_MIN:    min_q    <= pwdata;
				REG_OFFSET: offset_q <= pwdata;
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_GAP:    prdata = gap_q;
			REG_MIN:    prdata = min_q;
			REG_OFFSET: prdata = offset_q;
			default:    prdata = '0;
		endcase
	end

	// hold edges while the frame queue is full
	assign in_stall = q_full;

	rcpd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.edge_time    (edge_time),
		.gap_ticks    (gap_q),
		.min_ticks    (min_q),
		.offset_ticks (offset_q),
		.push         (push),
		.push_frame   (push_frame)
	);

	rcpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_frame (head_frame)
	);

	rcpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_frame   (head_frame),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.throttle     (throttle),
		.rudder       (rudder),
		.cyclic_front (cyclic_front),
		.cyclic_right (cyclic_right),
		.gyro_switch  (gyro_switch),
		.right_knob   (right_knob),
		.left_knob    (left_knob)
	);

endmodule

// ===== src/rcpd_checker.sv =====
// Port-level checks for the pulse channel decoder, bound to the top level.
`include "rc_pulse_channel_decoder_unmix_core_assert.svh"

module rcpd_port_checks import rcpd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  throttle,
	input logic [7:0]  rudder,
	input logic [7:0]  cyclic_front,
	input logic [7:0]  cyclic_right,
	input logic        gyro_switch,
	input logic [7:0]  right_knob,
	input logic [7:0]  left_knob,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	logic [48:0] result_bits;
	logic        held;
	logic [3:0]  addr_q;
	logic [31:0] wdata_q;
	logic        cfg_wr;
	logic        rd_ok;

	// gather the result fields and the stalled condition
	assign result_bits = {throttle, rudder, cyclic_front, cyclic_right, gyro_switch,
		right_knob, left_knob};
	assign held = out_valid && out_stall;

	// keep last cycle's address and write data for the read-back check
	always_ff @(posedge clk) begin
		addr_q  <= paddr;
		wdata_q <= pwdata;
	end

	assign cfg_wr = psel && penable && pwrite && pready && (paddr[3:2] <= REG_OFFSET);
	assign rd_ok  = (paddr != addr_q) || pwrite || (prdata == wdata_q);

	// a held result stays offered
	`RCPD_ASSERT_NEXT(a_out_hold, held, out_valid, "result dropped while stalled")

	// a held result keeps its values
	`RCPD_ASSERT_NEXT(a_out_stable, held, $stable(result_bits), "result changed while stalled")

	// the input side only backs up behind a waiting result
	`RCPD_ASSERT_NOW(a_stall_cause, in_stall, out_valid, "input stalled with empty output")

	// a written register reads back its new value
	`RCPD_ASSERT_NEXT(a_cfg_readback, cfg_wr, rd_ok, "register read back differs from write")

endmodule

bind rc_pulse_channel_decoder_unmix_core rcpd_port_checks u_rcpd_checker (.*);
